>>> hdl/lpbe_pkg.sv
// ----------------------------------------------------------------------------
// lpbe_pkg
// Shared types, codes and constants of the lightmap paint and blur engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbe_pkg;

  // built store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // fixed widths of the register and item fields
  localparam int DIM_W   = 9;
  localparam int PIX_W   = 24;
  localparam int PROD_W  = 27;   // 17-bit signed operand times 10-bit signed width
  localparam int IDX_W   = 28;   // product plus a 16-bit signed column
  localparam int ACC_W   = 11;   // four neighbors plus three times center
  localparam int QUO_W   = 25;   // ACC_W times RECIP7
  localparam int GSUM_W  = 10;
  localparam int GPROD_W = 21;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // APB register map
  localparam int  CFG_ADDR_W = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // floor(n/7) = (n * RECIP7) >> 16 for n < 13107
  localparam logic [13:0] RECIP7    = 14'd9363;
  localparam int          RECIP7_SH = 16;
  // floor(n/3) = (n * RECIP3) >> 12 for n < 2048
  localparam logic [10:0] RECIP3    = 11'd1366;
  localparam int          RECIP3_SH = 12;

  localparam logic [8:0] BLEND_ONE = 9'd256;

  // operation codes
  localparam logic FUNC_PAINT = 1'b0;
  localparam logic FUNC_BLUR  = 1'b1;

  // paint modes
  localparam logic [2:0] MODE_REPLACE = 3'd0;
  localparam logic [2:0] MODE_SUB     = 3'd1;
  localparam logic [2:0] MODE_ADD     = 3'd2;
  localparam logic [2:0] MODE_GRAY    = 3'd3;
  localparam logic [2:0] MODE_BLEND   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE         = 2'd0;
  localparam logic [1:0] ST_OUTSIDE      = 2'd1;
  localparam logic [1:0] ST_TEX_OUT      = 2'd2;
  localparam logic [1:0] ST_NOT_INTERIOR = 2'd3;

  // multiplier operand select
  localparam logic [1:0] MUL_SIDX = 2'd0;
  localparam logic [1:0] MUL_TIDX = 2'd1;
  localparam logic [1:0] MUL_SIZE = 2'd2;

  // read taps, walked in this order by the blur sequence
  localparam logic [2:0] TAP_C = 3'd0;
  localparam logic [2:0] TAP_L = 3'd1;
  localparam logic [2:0] TAP_R = 3'd2;
  localparam logic [2:0] TAP_U = 3'd3;
  localparam logic [2:0] TAP_D = 3'd4;

  // blur accumulator operations
  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_LOAD3 = 2'd1;
  localparam logic [1:0] ACC_ADD   = 2'd2;

  // result kinds
  localparam logic [1:0] OSEL_OUTSIDE      = 2'd0;
  localparam logic [1:0] OSEL_NOT_INTERIOR = 2'd1;
  localparam logic [1:0] OSEL_PAINT        = 2'd2;
  localparam logic [1:0] OSEL_BLUR         = 2'd3;

  typedef struct packed {
    logic               func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;
    logic [2:0]         mode;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [8:0]         blend_factor;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tex_offset;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sidx_ld;
    logic       tidx_ld;
    logic       chk;
    logic       rd_en;
    logic [2:0] rd_tap;
    logic [1:0] acc_op;
    logic       pix_ld;
    logic       div_ld;
    logic       wr_en;
    logic       out_load;
    logic [1:0] out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_blur;
    logic paint_oob;
    logic blur_bad;
  } dp_stat_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                               input int unsigned lim);
    logic [DIM_W-1:0] res;
    res = r;
    if (32'(r) > lim) begin
      res = DIM_W'(lim);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/lpbe_ram.sv
// ----------------------------------------------------------------------------
// lpbe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/lpbe_ctrl.sv
// ----------------------------------------------------------------------------
// lpbe_ctrl
// Sequencer: index products, range checks, paint and blur steps, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_strobe,
  output lpbe_pkg::dp_cmd_t      cmd,
  input  wire lpbe_pkg::dp_stat_t stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_P1   = 4'd5;
  localparam logic [3:0] S_P2   = 4'd6;
  localparam logic [3:0] S_BRD  = 4'd7;
  localparam logic [3:0] S_BACC = 4'd8;
  localparam logic [3:0] S_BDIV = 4'd9;
  localparam logic [3:0] S_BWR  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [2:0] tap_r, tap_nxt;
  logic       out_strobe_r;

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_M0;
        end
      end
      S_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lpbe_pkg::MUL_SIDX;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.sidx_ld = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lpbe_pkg::MUL_TIDX;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.tidx_ld = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lpbe_pkg::MUL_SIZE;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        cmd.rd_tap = lpbe_pkg::TAP_C;
        if (stat.is_blur) begin
          if (stat.blur_bad) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = lpbe_pkg::OSEL_NOT_INTERIOR;
            state_nxt    = S_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
            tap_nxt   = lpbe_pkg::TAP_L;
            state_nxt = S_BRD;
          end
        end else begin
          if (stat.paint_oob) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = lpbe_pkg::OSEL_OUTSIDE;
            state_nxt    = S_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_P1;
          end
        end
      end
      S_P1: begin
        cmd.pix_ld = 1'b1;
        state_nxt  = S_P2;
      end
      S_P2: begin
        cmd.wr_en    = 1'b1;
        cmd.out_load = 1'b1;
        cmd.out_sel  = lpbe_pkg::OSEL_PAINT;
        state_nxt    = S_IDLE;
      end
      S_BRD: begin
        // issue the next tap, fold in the data of the previous one
        cmd.rd_en  = 1'b1;
        cmd.rd_tap = tap_r;
        cmd.acc_op = (tap_r == lpbe_pkg::TAP_L) ? lpbe_pkg::ACC_LOAD3 : lpbe_pkg::ACC_ADD;
        if (tap_r == lpbe_pkg::TAP_D) begin
          state_nxt = S_BACC;
        end else begin
          tap_nxt = tap_r + 3'd1;
        end
      end
      S_BACC: begin
        cmd.acc_op = lpbe_pkg::ACC_ADD;
        state_nxt  = S_BDIV;
      end
      S_BDIV: begin
        cmd.div_ld = 1'b1;
        state_nxt  = S_BWR;
      end
      S_BWR: begin
        cmd.wr_en    = 1'b1;
        cmd.out_load = 1'b1;
        cmd.out_sel  = lpbe_pkg::OSEL_BLUR;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tap_r        <= lpbe_pkg::TAP_C;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tap_r        <= tap_nxt;
      out_strobe_r <= cmd.out_load;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;

endmodule

`default_nettype wire

>>> hdl/lpbe_dp.sv
// ----------------------------------------------------------------------------
// lpbe_dp
// Datapath: index multiplier, range compares, pixel store, paint modes,
// blur accumulator and divide by seven, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbe_dp (
  input  wire logic                         clk,
  input  wire lpbe_pkg::in_item_t           in_data,
  input  wire logic [lpbe_pkg::DIM_W-1:0]   cfg_width,
  input  wire logic [lpbe_pkg::DIM_W-1:0]   cfg_height,
  input  wire lpbe_pkg::dp_cmd_t            cmd,
  output lpbe_pkg::dp_stat_t                stat,
  output lpbe_pkg::out_item_t               out_data
);

  localparam int DW = lpbe_pkg::DIM_W;
  localparam int PW = lpbe_pkg::PROD_W;
  localparam int IW = lpbe_pkg::IDX_W;
  localparam int AW = lpbe_pkg::ADDR_W;
  localparam int CW = lpbe_pkg::ACC_W;
  localparam int QW = lpbe_pkg::QUO_W;
  localparam int GW = lpbe_pkg::GPROD_W;

  function automatic logic [7:0] clamp255(input logic signed [9:0] v);
    logic [7:0] res;
    if (v < 10'sd0) begin
      res = 8'd0;
    end else if (v > 10'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  lpbe_pkg::in_item_t  item_r;
  lpbe_pkg::out_item_t out_r, out_nxt;
  logic [DW-1:0]           w_r, h_r;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic signed [IW-1:0]    sidx_r, tidx_r;
  logic                    tex_oob_r;
  logic [16:0]             blend_r [3];
  logic [7:0]              gray_r;
  logic [7:0]              old_r [3];
  logic [CW-1:0]           acc_r [3];
  logic [QW-1:0]           quo_r [3];

  // ---------------- index multiplier ----------------
  logic signed [16:0]   mul_a;
  logic signed [PW-1:0] mul_a_e, mul_b_e;
  logic signed [16:0]   h_s, z_s;

  assign h_s = $signed({8'd0, h_r});
  assign z_s = 17'(item_r.pos_z);

  always_comb begin
    case (cmd.mul_sel)
      lpbe_pkg::MUL_SIDX: mul_a = h_s - z_s - 17'sd1;
      lpbe_pkg::MUL_TIDX: mul_a = z_s;
      lpbe_pkg::MUL_SIZE: mul_a = h_s;
      default:            mul_a = '0;
    endcase
  end

  assign mul_a_e  = PW'(mul_a);
  assign mul_b_e  = $signed(PW'(w_r));
  assign prod_nxt = mul_a_e * mul_b_e;

  logic signed [IW-1:0] idx_sum;
  assign idx_sum = IW'(prod_r) + IW'(item_r.pos_x);

  // ---------------- range checks (prod_r holds w*h here) ----------------
  logic signed [IW-1:0] size_e;
  logic signed [17:0]   x_e, z_e, w_e, he_e;
  logic                 tex_oob;

  assign size_e = IW'(prod_r);
  assign x_e    = 18'(item_r.pos_x);
  assign z_e    = 18'(item_r.pos_z);
  assign w_e    = $signed(18'(w_r));
  assign he_e   = $signed(18'(h_r));

  assign stat.is_blur   = (item_r.func == lpbe_pkg::FUNC_BLUR);
  assign stat.paint_oob = (prod_r == '0) || (sidx_r < 0) || (sidx_r >= size_e);
  assign stat.blur_bad  = (w_r < DW'(3)) || (h_r < DW'(3)) ||
                          (x_e < 18'sd1) || (x_e > w_e - 18'sd2) ||
                          (z_e < 18'sd1) || (z_e > he_e - 18'sd2);
  assign tex_oob        = (tidx_r < 0) || (tidx_r >= size_e);

  // ---------------- pixel store ----------------
  logic signed [IW-1:0] w_idx, tap_idx;
  logic [23:0]          rd_data, wr_data;

  assign w_idx = $signed(IW'(w_r));

  always_comb begin
    case (cmd.rd_tap)
      lpbe_pkg::TAP_C: tap_idx = sidx_r;
      lpbe_pkg::TAP_L: tap_idx = sidx_r - IW'(1);
      lpbe_pkg::TAP_R: tap_idx = sidx_r + IW'(1);
      lpbe_pkg::TAP_U: tap_idx = sidx_r - w_idx;
      lpbe_pkg::TAP_D: tap_idx = sidx_r + w_idx;
      default:         tap_idx = sidx_r;
    endcase
  end

  lpbe_ram #(
    .WIDTH (lpbe_pkg::PIX_W),
    .DEPTH (lpbe_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.wr_en),
    .waddr   (sidx_r[AW-1:0]),
    .wdata   (wr_data),
    .re      (cmd.rd_en),
    .raddr   (tap_idx[AW-1:0]),
    .rdata_r (rd_data)
  );

  // ---------------- paint ----------------
  logic [7:0]  rd_ch [3];
  logic [7:0]  new_ch [3];
  logic [8:0]  f_sat, f_inv;
  logic [lpbe_pkg::GSUM_W-1:0] gsum;
  logic [GW-1:0] gprod;
  logic [7:0]  paint_ch [3];

  assign rd_ch[0]  = rd_data[23:16];
  assign rd_ch[1]  = rd_data[15:8];
  assign rd_ch[2]  = rd_data[7:0];
  assign new_ch[0] = item_r.red_in;
  assign new_ch[1] = item_r.green_in;
  assign new_ch[2] = item_r.blue_in;

  assign f_sat = (item_r.blend_factor > lpbe_pkg::BLEND_ONE) ? lpbe_pkg::BLEND_ONE
                                                             : item_r.blend_factor;
  assign f_inv = lpbe_pkg::BLEND_ONE - f_sat;
  assign gsum  = lpbe_pkg::GSUM_W'(rd_ch[0]) + lpbe_pkg::GSUM_W'(rd_ch[1]) +
                 lpbe_pkg::GSUM_W'(rd_ch[2]);
  assign gprod = GW'(gsum) * GW'(lpbe_pkg::RECIP3);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [9:0] o_s, n_s;
      o_s = $signed({2'b00, old_r[k]});
      n_s = $signed({2'b00, new_ch[k]});
      case (item_r.mode)
        lpbe_pkg::MODE_REPLACE: paint_ch[k] = new_ch[k];
        lpbe_pkg::MODE_SUB:     paint_ch[k] = clamp255(o_s - n_s);
        lpbe_pkg::MODE_ADD:     paint_ch[k] = clamp255(o_s + n_s);
        lpbe_pkg::MODE_GRAY:    paint_ch[k] = clamp255($signed({2'b00, gray_r}) + n_s);
        lpbe_pkg::MODE_BLEND:   paint_ch[k] = blend_r[k][15:8];
        default:                paint_ch[k] = old_r[k];
      endcase
    end
  end

  // ---------------- blur ----------------
  logic [7:0] blur_ch [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      blur_ch[k] = quo_r[k][lpbe_pkg::RECIP7_SH +: 8];
    end
  end

  assign wr_data = stat.is_blur ? {blur_ch[0], blur_ch[1], blur_ch[2]}
                                : {paint_ch[0], paint_ch[1], paint_ch[2]};

  // ---------------- result ----------------
  always_comb begin
    out_nxt = '0;
    case (cmd.out_sel)
      lpbe_pkg::OSEL_OUTSIDE: begin
        out_nxt.status = lpbe_pkg::ST_OUTSIDE;
      end
      lpbe_pkg::OSEL_NOT_INTERIOR: begin
        out_nxt.status = lpbe_pkg::ST_NOT_INTERIOR;
      end
      lpbe_pkg::OSEL_PAINT: begin
        out_nxt.red_out   = paint_ch[0];
        out_nxt.green_out = paint_ch[1];
        out_nxt.blue_out  = paint_ch[2];
        if (tex_oob_r) begin
          out_nxt.status = lpbe_pkg::ST_TEX_OUT;
        end else begin
          out_nxt.status     = lpbe_pkg::ST_DONE;
          out_nxt.tex_offset = tidx_r[15:0];
        end
      end
      lpbe_pkg::OSEL_BLUR: begin
        out_nxt.status     = lpbe_pkg::ST_DONE;
        out_nxt.tex_offset = tidx_r[15:0];
        out_nxt.red_out    = blur_ch[0];
        out_nxt.green_out  = blur_ch[1];
        out_nxt.blue_out   = blur_ch[2];
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      w_r    <= lpbe_pkg::eff_dim(cfg_width, lpbe_pkg::MAX_WIDTH);
      h_r    <= lpbe_pkg::eff_dim(cfg_height, lpbe_pkg::MAX_HEIGHT);
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.sidx_ld) begin
      sidx_r <= idx_sum;
    end
    if (cmd.tidx_ld) begin
      tidx_r <= idx_sum;
    end
    if (cmd.chk) begin
      tex_oob_r <= tex_oob;
    end
    if (cmd.pix_ld) begin
      gray_r <= gprod[lpbe_pkg::RECIP3_SH +: 8];
      for (int k = 0; k < 3; k++) begin
        old_r[k]   <= rd_ch[k];
        blend_r[k] <= 17'(rd_ch[k]) * 17'(f_inv) + 17'(new_ch[k]) * 17'(f_sat);
      end
    end
    for (int k = 0; k < 3; k++) begin
      case (cmd.acc_op)
        lpbe_pkg::ACC_LOAD3: acc_r[k] <= CW'({rd_ch[k], 1'b0}) + CW'(rd_ch[k]);
        lpbe_pkg::ACC_ADD:   acc_r[k] <= acc_r[k] + CW'(rd_ch[k]);
        default:             acc_r[k] <= acc_r[k];
      endcase
    end
    if (cmd.div_ld) begin
      for (int k = 0; k < 3; k++) begin
        quo_r[k] <= QW'(acc_r[k]) * QW'(lpbe_pkg::RECIP7);
      end
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> hdl/lightmap_paint_blur_engine_core.sv
// ----------------------------------------------------------------------------
// lightmap_paint_blur_engine_core
// RGB888 lightmap store with paint (five blend modes) and 5-tap cross blur.
//
//   channel   ports                          transfer
//   input     start, busy, in_data           start & !busy at a clock edge
//   result    out_strobe, out_data           one cycle, no back-pressure
//   config    psel/penable/pwrite/paddr/...  APB, width @0x0, height @0x4
//
// Three products (store index, texture index, map size) share one multiplier
// in turn; blur reads its five pixels through the single store read port, one
// a cycle. Result shows in the same cycle that busy falls. Reset is
// synchronous and clears the control state and the configuration registers;
// the store is not cleared and needs no clearing pass. The receiver cannot
// stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module lightmap_paint_blur_engine_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire lpbe_pkg::in_item_t                  in_data,
  output logic                                     out_strobe,
  output lpbe_pkg::out_item_t                      out_data,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lpbe_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  logic [lpbe_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [lpbe_pkg::DIM_W-1:0] height_r, height_nxt;
  logic                       cfg_wr;
  logic                       reg_sel;

  lpbe_pkg::dp_cmd_t  cmd;
  lpbe_pkg::dp_stat_t stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (reg_sel)
        lpbe_pkg::REG_WIDTH:  width_nxt  = pwdata[lpbe_pkg::DIM_W-1:0];
        lpbe_pkg::REG_HEIGHT: height_nxt = pwdata[lpbe_pkg::DIM_W-1:0];
        default:              width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lpbe_pkg::DIM_RESET;
      height_r <= lpbe_pkg::DIM_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign prdata = (reg_sel == lpbe_pkg::REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

  lpbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .stat       (stat)
  );

  lpbe_dp u_dp (
    .clk        (clk),
    .in_data    (in_data),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> hdl/lpbe_chk.sv
// ----------------------------------------------------------------------------
// lpbe_chk
// Port-level checks of the engine's handshake and result encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbe_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire lpbe_pkg::in_item_t              in_data,
  input wire logic                            out_strobe,
  input wire lpbe_pkg::out_item_t             out_data,
  input wire logic                            psel,
  input wire logic                            penable,
  input wire logic                            pwrite,
  input wire logic [lpbe_pkg::CFG_ADDR_W-1:0] paddr,
  input wire logic [31:0]                     pwdata,
  input wire logic [31:0]                     prdata,
  input wire logic                            pready
);

  // an accepted transaction keeps the engine busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result closes a busy period
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy) && !busy)
    else $error("result strobe without a preceding busy period");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_data.status == lpbe_pkg::ST_OUTSIDE ||
                   out_data.status == lpbe_pkg::ST_NOT_INTERIOR) |->
      out_data.tex_offset == '0 && out_data.red_out == '0 &&
      out_data.green_out == '0 && out_data.blue_out == '0)
    else $error("rejected transaction returned nonzero fields");

  a_tex_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status == lpbe_pkg::ST_TEX_OUT |->
      out_data.tex_offset == '0)
    else $error("texture offset reported outside the texture");

endmodule

bind lightmap_paint_blur_engine_core lpbe_chk u_lpbe_chk (.*);

`default_nettype wire
